// File: design/tal_pkg.sv
package tal_pkg;

  // Default number of CORDIC micro-rotations in each chain.
  localparam int CORDIC_ITERATIONS_DEF = 16;
  // Largest number of micro-rotations the angle table supports.
  localparam int ANGLE_TABLE_LEN = 24;

  // Datapath widths: CORDIC x/y, CORDIC angle (Q30 radians).
  localparam int XW = 34;
  localparam int ZW = 33;
  // Remainder width of the steering demand divider and of the yaw divider.
  localparam int D1W = 32;
  localparam int D2W = 66;
  // Quotient bits of the two dividers.
  localparam int D1Q = 12;
  localparam int D2Q = 16;

  // Q4.12 constants.
  localparam logic [5:0]  YAW_DEADBAND = 6'd41;
  localparam logic [5:0]  MIN_DIVISOR  = 6'd41;
  localparam logic [11:0] BASE_SPEED   = 12'd614;
  localparam logic [10:0] DEMAND_SPEED = 11'd1434;
  localparam logic [12:0] ONE_Q12      = 13'd4096;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WHEELBASE = 2'd0;
  localparam logic [1:0] CFG_MAX_ANGLE = 2'd1;

  localparam logic [14:0] WHEELBASE_RST = 15'd1229;
  localparam logic [12:0] MAX_ANGLE_RST = 13'd2145;

  // Item fields that travel alongside the arithmetic.
  typedef struct packed {
    logic signed [15:0] speed;
    logic signed [15:0] yaw;
    logic               pass;
  } tal_item_t;

  typedef struct packed {
    tal_item_t item;
    logic      neg;
    logic      ovf;
  } tal_tail_t;

  // round(atan(2^-i) * 2^30)
  function automatic logic signed [ZW-1:0] atan_angle(input int unsigned idx);
    logic signed [ZW-1:0] a;
    begin
      case (idx)
        0:  a = 33'sd843314857;
        1:  a = 33'sd497837829;
        2:  a = 33'sd263043837;
        3:  a = 33'sd133525159;
        4:  a = 33'sd67021687;
        5:  a = 33'sd33543516;
        6:  a = 33'sd16775851;
        7:  a = 33'sd8388437;
        8:  a = 33'sd4194283;
        9:  a = 33'sd2097149;
        10: a = 33'sd1048576;
        11: a = 33'sd524288;
        12: a = 33'sd262144;
        13: a = 33'sd131072;
        14: a = 33'sd65536;
        15: a = 33'sd32768;
        16: a = 33'sd16384;
        17: a = 33'sd8192;
        18: a = 33'sd4096;
        19: a = 33'sd2048;
        20: a = 33'sd1024;
        21: a = 33'sd512;
        22: a = 33'sd256;
        23: a = 33'sd128;
        default: a = '0;
      endcase
      return a;
    end
  endfunction

endpackage

// File: design/tal_vec_cell.sv
module tal_vec_cell import tal_pkg::*; #(
  parameter int STEP = 0,
  parameter int PW   = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [XW-1:0] in_y,
  input  logic signed [ZW-1:0] in_z,
  input  logic [PW-1:0]        in_pay,
  output logic                 out_vld,
  output logic signed [XW-1:0] out_x,
  output logic signed [XW-1:0] out_y,
  output logic signed [ZW-1:0] out_z,
  output logic [PW-1:0]        out_pay
);

  // Vectoring step: drive y toward zero and accumulate the angle.
  localparam logic signed [ZW-1:0] ANGLE = atan_angle(STEP);

  logic                 vld_r;
  logic signed [XW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [PW-1:0]        pay_r;
  logic signed [XW-1:0] dx, dy;

  assign dx = in_y >>> STEP;
  assign dy = in_x >>> STEP;

  always_comb begin
    if (in_y > 0) begin
      x_nxt = in_x + dx;
      y_nxt = in_y - dy;
      z_nxt = in_z + ANGLE;
    end else begin
      x_nxt = in_x - dx;
      y_nxt = in_y + dy;
      z_nxt = in_z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    pay_r <= in_pay;
  end

  assign out_vld = vld_r;
  assign out_x   = x_r;
  assign out_y   = y_r;
  assign out_z   = z_r;
  assign out_pay = pay_r;

endmodule

// File: design/tal_rot_cell.sv
module tal_rot_cell import tal_pkg::*; #(
  parameter int STEP = 0,
  parameter int PW   = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic signed [XW-1:0] in_x,
  input  logic signed [XW-1:0] in_y,
  input  logic signed [ZW-1:0] in_z,
  input  logic [PW-1:0]        in_pay,
  output logic                 out_vld,
  output logic signed [XW-1:0] out_x,
  output logic signed [XW-1:0] out_y,
  output logic signed [ZW-1:0] out_z,
  output logic [PW-1:0]        out_pay
);

  // Rotation step: drive the residual angle toward zero.
  localparam logic signed [ZW-1:0] ANGLE = atan_angle(STEP);

  logic                 vld_r;
  logic signed [XW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [PW-1:0]        pay_r;
  logic signed [XW-1:0] dx, dy;

  assign dx = in_y >>> STEP;
  assign dy = in_x >>> STEP;

  always_comb begin
    if (in_z >= 0) begin
      x_nxt = in_x - dx;
      y_nxt = in_y + dy;
      z_nxt = in_z - ANGLE;
    end else begin
      x_nxt = in_x + dx;
      y_nxt = in_y - dy;
      z_nxt = in_z + ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    pay_r <= in_pay;
  end

  assign out_vld = vld_r;
  assign out_x   = x_r;
  assign out_y   = y_r;
  assign out_z   = z_r;
  assign out_pay = pay_r;

endmodule

// File: design/tal_div_cell.sv
module tal_div_cell #(
  parameter int W  = 32,
  parameter int QW = 12,
  parameter int SH = 0,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [W-1:0]  in_rem,
  input  logic [W-1:0]  in_den,
  input  logic [QW-1:0] in_q,
  input  logic [PW-1:0] in_pay,
  output logic          out_vld,
  output logic [W-1:0]  out_rem,
  output logic [W-1:0]  out_den,
  output logic [QW-1:0] out_q,
  output logic [PW-1:0] out_pay
);

  // One restoring division step for quotient bit SH.
  logic          vld_r;
  logic [W-1:0]  rem_r, rem_nxt, den_r, trial;
  logic [QW-1:0] q_r, q_nxt;
  logic [PW-1:0] pay_r;
  logic          fits;

  assign trial   = in_den << SH;
  assign fits    = in_rem >= trial;
  assign rem_nxt = fits ? in_rem - trial : in_rem;
  assign q_nxt   = {in_q[QW-2:0], fits};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= in_den;
    q_r   <= q_nxt;
    pay_r <= in_pay;
  end

  assign out_vld = vld_r;
  assign out_rem = rem_r;
  assign out_den = den_r;
  assign out_q   = q_r;
  assign out_pay = pay_r;

endmodule

// File: design/twist_to_ackermann_limiter.sv
// Throughput: one item per cycle; busy stays low, since every stage is a register cell.
// The pipeline depth is set by the three CORDIC cell rows and the two restoring divider rows.
// Reset (rst_n low at a clock edge) empties the pipeline and restores both registers.
// The receiver cannot stall: each result shows for exactly one cycle with out_valid.
module twist_to_ackermann_limiter import tal_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_speed_in,
  input  logic signed [15:0] in_yaw_rate_in,
  output logic               out_valid,
  output logic signed [15:0] out_speed_out,
  output logic signed [15:0] out_yaw_rate_out,
  output logic               out_yaw_saturated,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [14:0]        cfg_wdata
);

  // The angle table has a fixed length, so longer chains stop there.
  localparam int N = (CORDIC_ITERATIONS > ANGLE_TABLE_LEN) ? ANGLE_TABLE_LEN
                                                            : CORDIC_ITERATIONS;
  localparam int PI = $bits(tal_item_t);
  localparam int PT = $bits(tal_tail_t);

  // ---------------------------------------------------------------------------
  // Configuration registers. A zero value behaves as one.
  // ---------------------------------------------------------------------------
  logic [14:0] wheelbase_r;
  logic [12:0] max_angle_r;
  logic [14:0] wb;
  logic [12:0] amax;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheelbase_r <= WHEELBASE_RST;
      max_angle_r <= MAX_ANGLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WHEELBASE: wheelbase_r <= cfg_wdata;
        CFG_MAX_ANGLE: max_angle_r <= cfg_wdata[12:0];
        default:       ;
      endcase
    end
  end

  assign wb   = (wheelbase_r == '0) ? 15'd1 : wheelbase_r;
  assign amax = (max_angle_r == '0) ? 13'd1 : max_angle_r;

  // The pipeline takes an item every cycle.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Entry stage: deadband test and the first CORDIC vector. The speed used as
  // divisor is at least 0.01, and x carries it scaled by 4096 so that the
  // ratio y/x equals yaw*wheelbase/speed.
  // ---------------------------------------------------------------------------
  logic               acc;
  logic signed [16:0] v_in, w_in, av_in, d_in;
  logic signed [32:0] wl_in;
  tal_item_t          it_in;

  assign acc   = start && !busy;
  assign v_in  = 17'(in_speed_in);
  assign w_in  = 17'(in_yaw_rate_in);
  assign av_in = v_in[16] ? -v_in : v_in;
  assign d_in  = (av_in < 17'(MIN_DIVISOR)) ? 17'(MIN_DIVISOR) : av_in;
  assign wl_in = w_in * $signed({2'b0, wb});

  always_comb begin
    it_in.speed = in_speed_in;
    it_in.yaw   = in_yaw_rate_in;
    it_in.pass  = (w_in >= -$signed(17'(YAW_DEADBAND))) &&
                  (w_in <= $signed(17'(YAW_DEADBAND)));
  end

  logic                 e_vld_r;
  logic signed [XW-1:0] e_x_r, e_y_r;
  tal_item_t            e_it_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else begin
      e_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    e_x_r  <= XW'({d_in, 12'b0});
    e_y_r  <= XW'(wl_in);
    e_it_r <= it_in;
  end

  // ---------------------------------------------------------------------------
  // First atan chain: desired steering angle.
  // ---------------------------------------------------------------------------
  logic                 a1_v [0:N];
  logic signed [XW-1:0] a1_x [0:N];
  logic signed [XW-1:0] a1_y [0:N];
  logic signed [ZW-1:0] a1_z [0:N];
  logic [PI-1:0]        a1_p [0:N];

  assign a1_v[0] = e_vld_r;
  assign a1_x[0] = e_x_r;
  assign a1_y[0] = e_y_r;
  assign a1_z[0] = '0;
  assign a1_p[0] = e_it_r;

  for (genvar g = 0; g < N; g++) begin : g_atan1
    tal_vec_cell #(.STEP(g), .PW(PI)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (a1_v[g]),
      .in_x    (a1_x[g]),
      .in_y    (a1_y[g]),
      .in_z    (a1_z[g]),
      .in_pay  (a1_p[g]),
      .out_vld (a1_v[g+1]),
      .out_x   (a1_x[g+1]),
      .out_y   (a1_y[g+1]),
      .out_z   (a1_z[g+1]),
      .out_pay (a1_p[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Steering demand: |angle| / (max_angle*64), capped at 1.0. A quotient of
  // 4096 or more is caught up front, so the divider row needs only 12 bits.
  // ---------------------------------------------------------------------------
  logic [D1W-1:0] az1, b1;
  tal_tail_t      t1_in;

  assign az1 = a1_z[N][ZW-1] ? D1W'(-a1_z[N]) : D1W'(a1_z[N]);
  assign b1  = D1W'({amax, 6'b0});

  always_comb begin
    t1_in.item = a1_p[N];
    t1_in.neg  = 1'b0;
    t1_in.ovf  = az1 >= (b1 << D1Q);
  end

  logic           o1_vld_r;
  logic [D1W-1:0] o1_rem_r, o1_den_r;
  tal_tail_t      o1_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o1_vld_r <= 1'b0;
    end else begin
      o1_vld_r <= a1_v[N];
    end
  end

  always_ff @(posedge clk) begin
    o1_rem_r <= az1;
    o1_den_r <= b1;
    o1_t_r   <= t1_in;
  end

  logic           q1_v [0:D1Q];
  logic [D1W-1:0] q1_r [0:D1Q];
  logic [D1W-1:0] q1_d [0:D1Q];
  logic [D1Q-1:0] q1_q [0:D1Q];
  logic [PT-1:0]  q1_p [0:D1Q];

  assign q1_v[0] = o1_vld_r;
  assign q1_r[0] = o1_rem_r;
  assign q1_d[0] = o1_den_r;
  assign q1_q[0] = '0;
  assign q1_p[0] = o1_t_r;

  for (genvar g = 0; g < D1Q; g++) begin : g_div1
    tal_div_cell #(.W(D1W), .QW(D1Q), .SH(D1Q-1-g), .PW(PT)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (q1_v[g]),
      .in_rem  (q1_r[g]),
      .in_den  (q1_d[g]),
      .in_q    (q1_q[g]),
      .in_pay  (q1_p[g]),
      .out_vld (q1_v[g+1]),
      .out_rem (q1_r[g+1]),
      .out_den (q1_d[g+1]),
      .out_q   (q1_q[g+1]),
      .out_pay (q1_p[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Minimum speed 0.15 + 0.35*demand; outside the deadband the speed magnitude
  // is raised to it, keeping the sign, with zero taken as positive.
  // ---------------------------------------------------------------------------
  tal_tail_t          t1_out;
  logic [12:0]        dem;
  logic [23:0]        dem_prod;
  logic [11:0]        mts;
  logic signed [16:0] v1, av1;
  tal_item_t          it_m;

  assign t1_out   = q1_p[D1Q];
  assign dem      = t1_out.ovf ? ONE_Q12 : {1'b0, q1_q[D1Q]};
  assign dem_prod = dem * DEMAND_SPEED + 24'd2048;
  assign mts      = BASE_SPEED + 12'(dem_prod[23:12]);
  assign v1       = 17'(t1_out.item.speed);
  assign av1      = v1[16] ? -v1 : v1;

  always_comb begin
    it_m = t1_out.item;
    if (!t1_out.item.pass && (av1 < $signed({5'b0, mts}))) begin
      it_m.speed = v1[16] ? -$signed({4'b0, mts}) : $signed({4'b0, mts});
    end
  end

  logic      m_vld_r;
  tal_item_t m_it_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= q1_v[D1Q];
    end
  end

  always_ff @(posedge clk) begin
    m_it_r <= it_m;
  end

  // Second vector from the adjusted speed; yaw is mirrored for reverse motion.
  logic signed [16:0] v2, av2, w2, wadj;
  logic signed [33:0] wl2;

  assign v2   = 17'(m_it_r.speed);
  assign av2  = v2[16] ? -v2 : v2;
  assign w2   = 17'(m_it_r.yaw);
  assign wadj = v2[16] ? -w2 : w2;
  assign wl2  = wadj * $signed({2'b0, wb});

  logic                 n_vld_r;
  logic signed [XW-1:0] n_x_r, n_y_r;
  tal_item_t            n_it_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_vld_r <= 1'b0;
    end else begin
      n_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    n_x_r  <= XW'({av2, 12'b0});
    n_y_r  <= XW'(wl2);
    n_it_r <= m_it_r;
  end

  // ---------------------------------------------------------------------------
  // Second atan chain: steering angle for the adjusted speed.
  // ---------------------------------------------------------------------------
  logic                 a2_v [0:N];
  logic signed [XW-1:0] a2_x [0:N];
  logic signed [XW-1:0] a2_y [0:N];
  logic signed [ZW-1:0] a2_z [0:N];
  logic [PI-1:0]        a2_p [0:N];

  assign a2_v[0] = n_vld_r;
  assign a2_x[0] = n_x_r;
  assign a2_y[0] = n_y_r;
  assign a2_z[0] = '0;
  assign a2_p[0] = n_it_r;

  for (genvar g = 0; g < N; g++) begin : g_atan2
    tal_vec_cell #(.STEP(g), .PW(PI)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (a2_v[g]),
      .in_x    (a2_x[g]),
      .in_y    (a2_y[g]),
      .in_z    (a2_z[g]),
      .in_pay  (a2_p[g]),
      .out_vld (a2_v[g+1]),
      .out_x   (a2_x[g+1]),
      .out_y   (a2_y[g+1]),
      .out_z   (a2_z[g+1]),
      .out_pay (a2_p[g+1])
    );
  end

  // Clamp to the steering limit, which is max_angle in Q30.
  logic signed [ZW-1:0] lim, zc;

  assign lim = $signed(ZW'({amax, 18'b0}));

  always_comb begin
    zc = a2_z[N];
    if (zc > lim) begin
      zc = lim;
    end
    if (zc < -lim) begin
      zc = -lim;
    end
  end

  logic                 c_vld_r;
  logic signed [ZW-1:0] c_z_r;
  tal_item_t            c_it_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else begin
      c_vld_r <= a2_v[N];
    end
  end

  always_ff @(posedge clk) begin
    c_z_r  <= zc;
    c_it_r <= a2_p[N];
  end

  // ---------------------------------------------------------------------------
  // Rotation chain: gain-scaled cosine and sine of the clamped angle.
  // ---------------------------------------------------------------------------
  logic                 r_v [0:N];
  logic signed [XW-1:0] r_x [0:N];
  logic signed [XW-1:0] r_y [0:N];
  logic signed [ZW-1:0] r_z [0:N];
  logic [PI-1:0]        r_p [0:N];

  assign r_v[0] = c_vld_r;
  assign r_x[0] = XW'(64'sd1 <<< 30);
  assign r_y[0] = '0;
  assign r_z[0] = c_z_r;
  assign r_p[0] = c_it_r;

  for (genvar g = 0; g < N; g++) begin : g_rot
    tal_rot_cell #(.STEP(g), .PW(PI)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (r_v[g]),
      .in_x    (r_x[g]),
      .in_y    (r_y[g]),
      .in_z    (r_z[g]),
      .in_pay  (r_p[g]),
      .out_vld (r_v[g+1]),
      .out_x   (r_x[g+1]),
      .out_y   (r_y[g+1]),
      .out_z   (r_z[g+1]),
      .out_pay (r_p[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Yaw = 4096*|v|*|sin| / (wheelbase*cos). A non-positive cosine is taken as
  // one, which makes the yaw saturate.
  // ---------------------------------------------------------------------------
  tal_item_t          it_r;
  logic signed [16:0] vr, avr;
  logic [31:0]        cxr, asy;
  logic [48:0]        pnum;
  logic [46:0]        pden;

  assign it_r = r_p[N];
  assign vr   = 17'(it_r.speed);
  assign avr  = vr[16] ? -vr : vr;
  assign cxr  = (r_x[N] < 1) ? 32'd1 : r_x[N][31:0];
  assign asy  = r_y[N][XW-1] ? 32'(-r_y[N]) : 32'(r_y[N]);
  assign pnum = avr[15:0] * asy + {16'b0, avr[16], 32'b0};
  assign pden = wb * cxr;

  logic        p_vld_r;
  logic [48:0] p_num_r;
  logic [46:0] p_den_r;
  tal_tail_t   p_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r <= 1'b0;
    end else begin
      p_vld_r <= r_v[N];
    end
  end

  always_ff @(posedge clk) begin
    p_num_r    <= pnum;
    p_den_r    <= pden;
    p_t_r.item <= it_r;
    p_t_r.neg  <= vr[16] != r_y[N][XW-1];
    p_t_r.ovf  <= 1'b0;
  end

  // Rounded division as floor((8192*num + den) / (2*den)); a quotient of 65536
  // or more is flagged up front so the divider row needs only 16 bits.
  logic [D2W-1:0] n2, den2;
  tal_tail_t      t2_in;

  assign n2   = (D2W'(p_num_r) << 13) + D2W'(p_den_r);
  assign den2 = D2W'(p_den_r) << 1;

  always_comb begin
    t2_in     = p_t_r;
    t2_in.ovf = n2 >= (den2 << D2Q);
  end

  logic           o2_vld_r;
  logic [D2W-1:0] o2_rem_r, o2_den_r;
  tal_tail_t      o2_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o2_vld_r <= 1'b0;
    end else begin
      o2_vld_r <= p_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    o2_rem_r <= n2;
    o2_den_r <= den2;
    o2_t_r   <= t2_in;
  end

  logic           q2_v [0:D2Q];
  logic [D2W-1:0] q2_r [0:D2Q];
  logic [D2W-1:0] q2_d [0:D2Q];
  logic [D2Q-1:0] q2_q [0:D2Q];
  logic [PT-1:0]  q2_p [0:D2Q];

  assign q2_v[0] = o2_vld_r;
  assign q2_r[0] = o2_rem_r;
  assign q2_d[0] = o2_den_r;
  assign q2_q[0] = '0;
  assign q2_p[0] = o2_t_r;

  for (genvar g = 0; g < D2Q; g++) begin : g_div2
    tal_div_cell #(.W(D2W), .QW(D2Q), .SH(D2Q-1-g), .PW(PT)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_vld  (q2_v[g]),
      .in_rem  (q2_r[g]),
      .in_den  (q2_d[g]),
      .in_q    (q2_q[g]),
      .in_pay  (q2_p[g]),
      .out_vld (q2_v[g+1]),
      .out_rem (q2_r[g+1]),
      .out_den (q2_d[g+1]),
      .out_q   (q2_q[g+1]),
      .out_pay (q2_p[g+1])
    );
  end

  // ---------------------------------------------------------------------------
  // Output register: sign, saturation, and the deadband pass-through.
  // ---------------------------------------------------------------------------
  tal_tail_t          t2_out;
  logic [15:0]        qf;
  logic signed [15:0] yaw_nxt;
  logic               sat_nxt;

  assign t2_out = q2_p[D2Q];
  assign qf     = q2_q[D2Q];

  always_comb begin
    yaw_nxt = t2_out.item.yaw;
    sat_nxt = 1'b0;
    if (!t2_out.item.pass) begin
      if (!t2_out.neg) begin
        if (t2_out.ovf || qf[15]) begin
          yaw_nxt = 16'sh7fff;
          sat_nxt = 1'b1;
        end else begin
          yaw_nxt = $signed(qf);
        end
      end else begin
        if (t2_out.ovf || (qf > 16'h8000)) begin
          yaw_nxt = 16'sh8000;
          sat_nxt = 1'b1;
        end else begin
          yaw_nxt = -$signed(qf);
        end
      end
    end
  end

  logic               out_valid_r;
  logic signed [15:0] speed_out_r, yaw_out_r;
  logic               sat_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= q2_v[D2Q];
    end
  end

  always_ff @(posedge clk) begin
    speed_out_r <= t2_out.item.speed;
    yaw_out_r   <= yaw_nxt;
    sat_out_r   <= sat_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_speed_out     = speed_out_r;
  assign out_yaw_rate_out  = yaw_out_r;
  assign out_yaw_saturated = sat_out_r;

endmodule

// File: design/tal_checker.sv
module tal_checker #(
  parameter int LATENCY = 84
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [15:0] in_speed_in,
  input logic signed [15:0] in_yaw_rate_in,
  input logic               out_valid,
  input logic signed [15:0] out_speed_out,
  input logic signed [15:0] out_yaw_rate_out,
  input logic               out_yaw_saturated,
  input logic               cfg_we,
  input logic [1:0]         cfg_index,
  input logic [14:0]        cfg_wdata
);

  // Every accepted item comes out with out_valid.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("item result missing at fixed latency");

  // Nothing comes out in the cycle after a reset edge.
  a_reset_flush: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");

  // A saturated yaw sits at one end of its range.
  a_sat_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_yaw_saturated) |->
      (out_yaw_rate_out == 16'sh7fff || out_yaw_rate_out == 16'sh8000))
    else $error("saturated yaw not at range end");

  // The speed of an item with a saturated yaw is never below the base speed magnitude.
  a_speed_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_yaw_saturated) |->
      (out_speed_out >= 16'sd614 || out_speed_out <= -16'sd614))
    else $error("speed below floor on a steered item");

endmodule

bind twist_to_ackermann_limiter tal_checker #(
  .LATENCY(3 * ((CORDIC_ITERATIONS > 24) ? 24 : CORDIC_ITERATIONS) + 36)
) u_tal_checker (.*);

// File: bench/tb_top.sv
`default_nettype none

// Scoreboard for the limiter. It keeps its own copy of both registers and,
// for each item that the block accepts, works out the speed and yaw rate that
// must come back. Results come back in order, so a queue is enough.
class steer_scoreboard;
  typedef struct {
    logic signed [15:0] speed;
    logic signed [15:0] yaw;
    logic               sat;
  } steer_cmd_t;

  localparam int STEPS = 16;

  longint     wheelbase_q = 1229;
  longint     max_angle_q = 2145;
  steer_cmd_t expected_q[$];
  int         errors;
  longint     angle_step[24];

  function new();
    angle_step = '{843314857, 497837829, 263043837, 133525159, 67021687,
                   33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                   524288, 262144, 131072, 65536, 32768, 16384, 8192, 4096,
                   2048, 1024, 512, 256, 128};
  endfunction

  function void write_reg(logic [1:0] idx, logic [14:0] data);
    if (idx == tal_pkg::CFG_WHEELBASE) wheelbase_q = data;
    else if (idx == tal_pkg::CFG_MAX_ANGLE) max_angle_q = data[12:0];
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  static function longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // Vectoring CORDIC: angle of (x, y) in Q30 radians, x positive.
  function longint vector_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += angle_step[i];
      end else begin
        x -= dx; y += dy; z -= angle_step[i];
      end
    end
    return z;
  endfunction

  // Rotation CORDIC from unit x: gain-scaled cosine and sine of z.
  function void rotate_unit(longint z, output longint cx, output longint sy);
    longint x, y, dx, dy;
    x = longint'(1) << 30;
    y = 0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= angle_step[i];
      end else begin
        x += dx; y -= dy; z += angle_step[i];
      end
    end
    cx = x;
    sy = y;
  endfunction

  function steer_cmd_t limit_command(logic signed [15:0] sp, logic signed [15:0] yw);
    steer_cmd_t r;
    longint v, w, wb, lim_a, av, d, z, demand, min_sp, lim, cx, sy;
    longint unsigned num, den, q;
    logic neg;
    v = sp;
    w = yw;
    wb = wheelbase_q != 0 ? wheelbase_q : 1;
    lim_a = max_angle_q != 0 ? max_angle_q : 1;
    r.sat = 1'b0;
    if (mag(w) <= 41) begin
      r.speed = sp;
      r.yaw = yw;
      return r;
    end
    av = mag(v);
    d = av < 41 ? 41 : av;
    z = vector_angle(d * 4096, w * wb);
    demand = mag(z) / (lim_a * 64);
    if (demand > 4096) demand = 4096;
    min_sp = 614 + ((demand * 1434 + 2048) >>> 12);
    if (av < min_sp) v = (v >= 0) ? min_sp : -min_sp;
    av = mag(v);
    z = vector_angle(av * 4096, (v < 0 ? -w : w) * wb);
    lim = lim_a * 262144;
    if (z > lim) z = lim;
    if (z < -lim) z = -lim;
    rotate_unit(z, cx, sy);
    if (cx < 1) cx = 1;
    neg = (v < 0) != (sy < 0);
    num = longint'(av) * longint'(mag(sy)) * 4096;
    den = longint'(wb) * longint'(cx);
    q = (num + den / 2) / den;
    if (!neg) begin
      if (q > 32767) begin
        q = 32767; r.sat = 1'b1;
      end
      r.yaw = q[15:0];
    end else begin
      if (q > 32768) begin
        q = 32768; r.sat = 1'b1;
      end
      r.yaw = -q[15:0];
    end
    r.speed = v[15:0];
    return r;
  endfunction

  function void note_item(logic signed [15:0] sp, logic signed [15:0] yw);
    expected_q.push_back(limit_command(sp, yw));
  endfunction

  function void check_result(logic signed [15:0] sp, logic signed [15:0] yw, logic sat);
    steer_cmd_t e;
    if (expected_q.size() == 0) begin
      $display("%0t: result with nothing expected: speed %0d yaw %0d sat %0b",
               $time, sp, yw, sat);
      errors++;
      return;
    end
    e = expected_q.pop_front();
    if (sp !== e.speed) begin
      $display("%0t: speed_out expected %0d actual %0d", $time, e.speed, sp);
      errors++;
    end
    if (yw !== e.yaw) begin
      $display("%0t: yaw_rate_out expected %0d actual %0d", $time, e.yaw, yw);
      errors++;
    end
    if (sat !== e.sat) begin
      $display("%0t: yaw_saturated expected %0b actual %0b", $time, e.sat, sat);
      errors++;
    end
  endfunction
endclass

module tb_top import tal_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // An index past the register list; the block must ignore writes to it.
  localparam logic [1:0] CFG_SPARE = 2'd2;
  // Cycles without any accepted item or result before the run is abandoned.
  // The pipeline is 84 deep and sender gaps are short, so this is generous.
  localparam int STALL_LIMIT = 3000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [15:0] in_speed_in;
  logic signed [15:0] in_yaw_rate_in;
  logic               out_valid;
  logic signed [15:0] out_speed_out;
  logic signed [15:0] out_yaw_rate_out;
  logic               out_yaw_saturated;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [14:0]        cfg_wdata;

  steer_scoreboard steer_sb;
  bit              steady_feed;
  int              stall_cycles;

  twist_to_ackermann_limiter dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_speed_in(in_speed_in), .in_yaw_rate_in(in_yaw_rate_in),
    .out_valid(out_valid), .out_speed_out(out_speed_out),
    .out_yaw_rate_out(out_yaw_rate_out), .out_yaw_saturated(out_yaw_saturated),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Results are sampled at the edge that ends their cycle, before the block
  // updates its outputs, so the order of events within the step does not matter.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      steer_sb.check_result(out_speed_out, out_yaw_rate_out, out_yaw_saturated);
  end

  // Watchdog: counts cycles in which neither an item nor a result moves.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Presents one item and holds it until the block takes it. Start is left
  // high so that back-to-back items need no extra cycle.
  task automatic send_item(input logic signed [15:0] sp, input logic signed [15:0] yw);
    start <= 1'b1;
    in_speed_in <= sp;
    in_yaw_rate_in <= yw;
    do @(posedge clk); while (busy);
    steer_sb.note_item(sp, yw);
  endtask

  // Idle cycles before an item: each cycle idles with a chance of about a
  // third, unless the feed is meant to be steady.
  task automatic maybe_idle();
    if (!steady_feed) begin
      while ($urandom_range(99) < 34) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // Lowers start and waits until every expected result has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (steer_sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write; only ever called once the pipeline has drained. The
  // enable drops after each write so that writes never run together.
  task automatic write_reg(input logic [1:0] idx, input logic [14:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    steer_sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Random item. Most yaw rates lie outside the pass-through band, some sit
  // on its edge, and speeds are often small so that the minimum-speed lift
  // is exercised.
  task automatic send_random();
    logic signed [15:0] sp, yw;
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) sp = 16'(int'($urandom_range(0, 6000)) - 3000);
    else sp = 16'($urandom());
    pick = $urandom_range(99);
    if (pick < 15) yw = 16'(int'($urandom_range(0, 82)) - 41);
    else if (pick < 25) yw = $urandom_range(1) ? 16'sd42 : -16'sd42;
    else if (pick < 55) yw = 16'(int'($urandom_range(0, 8000)) - 4000);
    else yw = 16'($urandom());
    maybe_idle();
    send_item(sp, yw);
  endtask

  task automatic random_phase(input int count);
    repeat (count) send_random();
    drain();
  endtask

  initial begin
    steer_sb = new();
    steady_feed = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_speed_in = '0;
    in_yaw_rate_in = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_WHEELBASE;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items at the reset settings: field extremes, both edges of the
    // pass-through band, zero and tiny speeds that need lifting, and large
    // yaw rates that drive the steering into its limit.
    send_item(16'sd0, 16'sd0);
    send_item(16'sd32767, 16'sd41);
    send_item(-16'sd32768, -16'sd41);
    send_item(16'sd100, 16'sd42);
    send_item(-16'sd100, -16'sd42);
    send_item(16'sd0, 16'sd4096);
    send_item(16'sd0, -16'sd4096);
    send_item(16'sd10, 16'sd32767);
    send_item(-16'sd10, -16'sd32768);
    send_item(16'sd32767, 16'sd32767);
    send_item(-16'sd32768, 16'sd32767);
    send_item(16'sd32767, -16'sd32768);
    send_item(-16'sd32768, -16'sd32768);
    send_item(16'sd4096, 16'sd2048);
    send_item(-16'sd4096, 16'sd2048);
    send_item(16'sd614, -16'sd500);
    send_item(-16'sd1, 16'sd1000);
    send_item(16'sd40, -16'sd20000);
    drain();
    random_phase(50);

    // Shortest wheelbase and tightest steering limit.
    write_reg(CFG_WHEELBASE, 15'd1);
    write_reg(CFG_MAX_ANGLE, 15'd1);
    send_item(16'sd0, 16'sd32767);
    send_item(-16'sd32768, -16'sd32768);
    random_phase(50);

    // Longest wheelbase and the widest limit below a right angle. This phase
    // also runs without gaps so the pipeline stays full.
    write_reg(CFG_WHEELBASE, 15'd32767);
    write_reg(CFG_MAX_ANGLE, 15'd6433);
    steady_feed = 1'b1;
    send_item(16'sd32767, 16'sd32767);
    send_item(16'sd0, -16'sd32768);
    random_phase(70);
    steady_feed = 1'b0;

    // Zero in both registers must behave as the smallest legal value.
    write_reg(CFG_WHEELBASE, 15'd0);
    write_reg(CFG_MAX_ANGLE, 15'd0);
    random_phase(40);

    // A limit past a right angle, written with stray upper data bits that
    // the register must drop; the clamp then never bites. A write to an
    // unused index must change nothing.
    write_reg(CFG_WHEELBASE, 15'd4096);
    write_reg(CFG_MAX_ANGLE, 15'h7FFF);
    write_reg(CFG_SPARE, 15'h5555);
    send_item(16'sd0, 16'sd32767);
    send_item(16'sd100, -16'sd32768);
    random_phase(50);

    // A few random settings to finish.
    repeat (3) begin
      write_reg(CFG_WHEELBASE, 15'($urandom_range(1, 32767)));
      write_reg(CFG_MAX_ANGLE, 15'($urandom_range(1, 8191)));
      random_phase(40);
    end

    drain();
    repeat (20) @(posedge clk);
    if (steer_sb.errors == 0 && steer_sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
